[src/tdcw_pkg.sv]
// Shared types and constants for the TDC channel window counter.
package tdcw_pkg;

    localparam int MAX_CHANNELS = 6;
    localparam int WORD_W       = 32;
    localparam int TICK_W       = 28;
    localparam int CNT_W        = 32;
    localparam int SETUP_W      = 64;
    localparam int PERIOD_W     = 56;
    localparam int LIMIT_W      = 31;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 64;
    localparam int SUM_W        = 30;   // |t - d + f| needs 29 bits plus sign
    localparam int REM_W        = 29;

    localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 3'd7;

    typedef enum logic [1:0] {
        OUT_MARKER  = 2'd0,
        OUT_GATED   = 2'd1,
        OUT_CURRENT = 2'd2,
        OUT_FUTURE  = 2'd3
    } outcome_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_APPLY,
        BK_HOLD
    } bk_state_t;

    // Classified transaction passed from front to back
    typedef struct packed {
        logic [2:0]          channel;
        logic [TICK_W-1:0]   ticks;
        logic                buffer_start;
        logic                is_marker;
        logic                off_range;
    } front_item_t;

endpackage

[src/tdcw_front.sv]
// Front part: classifies each input word and stores it in a two-entry queue.
module tdcw_front
    import tdcw_pkg::*;
#(
    parameter int CHANNELS = MAX_CHANNELS
)(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [WORD_W-1:0]   in_word,
    input  logic                in_start,
    output logic                q_valid,
    input  logic                q_pop,
    output front_item_t         q_item
);

    front_item_t slot_reg [2];
    logic [1:0]  wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg;
    logic [1:0]  cnt_reg, cnt_next;
    logic        push;
    front_item_t item;

    always_comb
    begin
        item.channel      = in_word[30:28];
        item.ticks        = in_word[TICK_W-1:0];
        item.buffer_start = in_start;
        item.is_marker    = (in_word[30:28] == 3'd0) || (in_word[30:28] == 3'd7);
        item.off_range    = (32'(in_word[30:28]) > 32'(CHANNELS));
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = {1'b0, ~wr_ptr_reg[0]};
        end
        case ({push, q_pop && q_valid})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            cnt_reg    <= cnt_next;
            if (q_pop && q_valid)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg[0]] <= item;
        end
    end

endmodule

[src/tdcw_remainder.sv]
// Restoring iterative remainder of a 29-bit magnitude by a 28-bit period.
module tdcw_remainder
    import tdcw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [REM_W-1:0]   dividend,
    input  logic [TICK_W-1:0]  divisor,
    output logic               done,
    output logic [REM_W-1:0]   remainder
);

    localparam int STEP_W = $clog2(REM_W + 1);

    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [REM_W-1:0]  quo_reg, quo_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic [REM_W:0]    trial;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        trial     = {rem_reg, quo_reg[REM_W-1]} - {2'b00, divisor};
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            step_next = STEP_W'(REM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[REM_W])
            begin
                rem_next = trial[REM_W-1:0];
            end
            else
            begin
                rem_next = {rem_reg[REM_W-2:0], quo_reg[REM_W-1]};
            end
            quo_next  = {quo_reg[REM_W-2:0], 1'b0};
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            done     <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            done     <= busy_reg && !busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign remainder = rem_reg;

endmodule

[src/tdcw_back.sv]
// Back part: gate check, window compare, counters and output register.
module tdcw_back
    import tdcw_pkg::*;
#(
    parameter int CHANNELS = MAX_CHANNELS
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    output logic                  q_pop,
    input  front_item_t           q_item,
    input  logic [SETUP_W-1:0]    setup [CHANNELS],
    input  logic [PERIOD_W-1:0]   periods,
    input  logic [LIMIT_W-1:0]    limit,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [2:0]            out_channel,
    output logic [1:0]            out_outcome,
    output logic [CNT_W-1:0]      out_count,
    output logic [CNT_W-1:0]      out_frames
);

    localparam int K_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    bk_state_t state_reg, state_next;

    logic [CNT_W-1:0] cur_reg [CHANNELS];
    logic [CNT_W-1:0] fut_reg [CHANNELS];
    logic [CNT_W-1:0] marker_reg;

    front_item_t      item_reg;
    logic             neg_reg;
    logic             gate_ok_reg;
    logic [2:0]       ch_o_reg;
    logic [1:0]       oc_o_reg;
    logic [CNT_W-1:0] cnt_o_reg;
    logic [CNT_W-1:0] frm_o_reg;

    logic [K_W-1:0]       k;
    logic [SETUP_W-1:0]   sel;
    logic [TICK_W-1:0]    d_sel, g_sel, p_val, f_val;
    logic signed [SUM_W-1:0] s_val;
    logic [REM_W-1:0]     mag;
    logic                 gate_on;
    logic                 div_start, div_done;
    logic [REM_W-1:0]     rem;
    logic signed [SUM_W+1:0] diff;
    logic [CNT_W-1:0]     mk_base;
    logic [CNT_W:0]       idx;
    logic                 is_cur;

    assign k       = K_W'(item_reg.channel - 3'd1);
    assign sel     = setup[k];
    assign d_sel   = sel[55:28];
    assign g_sel   = sel[27:0];
    assign f_val   = periods[55:28];
    assign p_val   = periods[27:0];
    assign gate_on = sel[63] && (p_val != '0);
    assign s_val   = SUM_W'(item_reg.ticks) - SUM_W'(d_sel) + SUM_W'(f_val);
    assign mag     = s_val[SUM_W-1] ? REM_W'(-s_val) : REM_W'(s_val);

    // P - r with r carrying the sign of s
    assign diff = neg_reg ? (SUM_W+2)'(p_val) + (SUM_W+2)'(rem)
                          : (SUM_W+2)'(p_val) - (SUM_W+2)'(rem);

    assign mk_base = item_reg.buffer_start ? '0 : marker_reg;
    assign idx     = (CNT_W+1)'(mk_base) + (CNT_W+1)'(sel[62:56]);
    assign is_cur  = (idx < (CNT_W+1)'(limit)) ||
                     ((idx == (CNT_W+1)'(limit)) && (item_reg.ticks < d_sel));

    tdcw_remainder u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (mag),
        .divisor   (p_val),
        .done      (div_done),
        .remainder (rem)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
                if (q_valid && (!out_valid || out_ready))
                begin
                    state_next = BK_HOLD;
                end
            BK_HOLD:
                if (!item_reg.is_marker && !item_reg.off_range && gate_on)
                begin
                    state_next = BK_DIV;
                end
                else
                begin
                    state_next = BK_APPLY;
                end
            BK_DIV:
                if (div_done)
                begin
                    state_next = BK_APPLY;
                end
            BK_APPLY:
                state_next = BK_IDLE;
            default:
                state_next = BK_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        q_pop     = 1'b0;
        div_start = 1'b0;
        case (state_reg)
            BK_IDLE:  q_pop = q_valid && (!out_valid || out_ready);
            BK_HOLD:  div_start = !item_reg.is_marker && !item_reg.off_range && gate_on;
            default:  q_pop = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= BK_IDLE;
            marker_reg <= '0;
            out_valid  <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                cur_reg[i] <= '0;
                fut_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid && out_ready)
            begin
                out_valid <= 1'b0;
            end
            if (state_reg == BK_APPLY)
            begin
                out_valid <= 1'b1;
                if (item_reg.is_marker)
                begin
                    marker_reg <= (mk_base == '1) ? mk_base : mk_base + 1'b1;
                end
                else
                begin
                    marker_reg <= mk_base;
                    if (!item_reg.off_range && gate_ok_reg)
                    begin
                        if (is_cur)
                        begin
                            if (cur_reg[k] != '1)
                            begin
                                cur_reg[k] <= cur_reg[k] + 1'b1;
                            end
                        end
                        else if (fut_reg[k] != '1)
                        begin
                            fut_reg[k] <= fut_reg[k] + 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            item_reg <= q_item;
        end
        if (state_reg == BK_HOLD)
        begin
            neg_reg     <= s_val[SUM_W-1];
            gate_ok_reg <= 1'b1;
        end
        if (state_reg == BK_DIV && div_done)
        begin
            gate_ok_reg <= (diff <= (SUM_W+2)'(g_sel));
        end
        if (state_reg == BK_APPLY)
        begin
            ch_o_reg  <= item_reg.channel;
            cnt_o_reg <= '0;
            if (item_reg.is_marker)
            begin
                oc_o_reg  <= OUT_MARKER;
                frm_o_reg <= (mk_base == '1) ? mk_base : mk_base + 1'b1;
            end
            else
            begin
                frm_o_reg <= mk_base;
                if (item_reg.off_range || !gate_ok_reg)
                begin
                    oc_o_reg <= OUT_GATED;
                end
                else if (is_cur)
                begin
                    oc_o_reg  <= OUT_CURRENT;
                    cnt_o_reg <= (cur_reg[k] == '1) ? cur_reg[k] : cur_reg[k] + 1'b1;
                end
                else
                begin
                    oc_o_reg  <= OUT_FUTURE;
                    cnt_o_reg <= (fut_reg[k] == '1) ? fut_reg[k] : fut_reg[k] + 1'b1;
                end
            end
        end
    end

    assign out_channel = ch_o_reg;
    assign out_outcome = oc_o_reg;
    assign out_count   = cnt_o_reg;
    assign out_frames  = frm_o_reg;

endmodule

[src/tdc_channel_window_counter_core.sv]
// Top level of the TDC channel window counter.
//
// s_axis carries one converter word per transaction: tdata[31:0] is the raw
// word (channel in 30:28, ticks in 27:0), tuser is buffer_start, which clears
// the frame marker count before the word is handled.
// m_axis returns one result per input word: channel, outcome, count after
// update and marker count (packing beside the port).
// cfg_* writes one setup register per transaction (index 0..5 channel setup,
// 6 periods, 7 frame limit); write only while the block is idle.
// Markers, ungated hits and off-range channels pass the back end states idle,
// hold and apply, which sets m_axis_tvalid; a gated hit also passes the divide
// state, in which the restoring remainder unit works, one quotient bit per cycle
// over 29 bits. One item is processed at a time in the back end, so a new item
// starts only after the last one is applied and while the receiver keeps up.
// A two-entry queue decouples input acceptance from processing, and the result
// register holds the last result while m_axis_tready is low; the back end
// then waits before starting the next item.
// Reset clears all counters, the configuration registers, the back end state, the queue and the output valid.
module tdc_channel_window_counter_core
    import tdcw_pkg::*;
#(
    parameter int CHANNELS = MAX_CHANNELS
)(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [31:0]            s_axis_tdata,   // sample_word
    input  logic                   s_axis_tuser,   // buffer_start
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [71:0]            m_axis_tdata,   // hit_channel, outcome, count_after, frames_seen (bits 68:0), zero pad
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [SETUP_W-1:0]  setup_reg [CHANNELS];
    logic [PERIOD_W-1:0] period_reg;
    logic [LIMIT_W-1:0]  limit_reg;

    logic        q_valid, q_pop;
    front_item_t q_item;
    logic [2:0]        o_ch;
    logic [1:0]        o_oc;
    logic [CNT_W-1:0]  o_cnt, o_frm;

    assign cfg_ready = 1'b1;

    // register file; setup indexes from the channel count up are dropped, 6 and 7 go to periods and limit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                setup_reg[i] <= '0;
            end
            period_reg <= '0;
            limit_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_PERIOD)
            begin
                period_reg <= cfg_data[PERIOD_W-1:0];
            end
            else if (cfg_index == REG_LIMIT)
            begin
                limit_reg <= cfg_data[LIMIT_W-1:0];
            end
            else
            begin
                for (int i = 0; i < CHANNELS; i++)
                begin
                    if (cfg_index == CFG_IDX_W'(i))
                    begin
                        setup_reg[i] <= cfg_data;
                    end
                end
            end
        end
    end

    tdcw_front #(.CHANNELS(CHANNELS)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_word  (s_axis_tdata),
        .in_start (s_axis_tuser),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item)
    );

    tdcw_back #(.CHANNELS(CHANNELS)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_item      (q_item),
        .setup       (setup_reg),
        .periods     (period_reg),
        .limit       (limit_reg),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_channel (o_ch),
        .out_outcome (o_oc),
        .out_count   (o_cnt),
        .out_frames  (o_frm)
    );

    assign m_axis_tdata = {3'b000, o_frm, o_cnt, o_oc, o_ch};

endmodule
